[rtl/vdm_pkg.sv]
// shared constants, types and helpers for the valid depth median 3x3 core
`timescale 1ns / 1ps

package vdm_pkg;

  localparam int VDM_SAMPLE_BITS       = 16;
  localparam int VDM_COORD_BITS        = 12;
  localparam int WIN_TAPS              = 9;
  localparam int CNT_BITS              = 4;
  localparam int DIM_BITS              = 13;
  localparam int SORT_STAGES           = 3;
  localparam int SORT_LAYERS_PER_STAGE = 3;
  localparam int IDX_BITS              = 4;
  localparam int CFG_IDX_BITS          = 1;

  localparam logic [DIM_BITS-1:0] FRAME_WIDTH_RST  = DIM_BITS'(1280);
  localparam logic [DIM_BITS-1:0] FRAME_HEIGHT_RST = DIM_BITS'(720);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic                valid;
    logic [CNT_BITS-1:0] count;
  } vdm_ctrl_t;

  // position of the upper median among all nine sorted taps, zeros first
  function automatic logic [IDX_BITS-1:0] median_index(input logic [CNT_BITS-1:0] count);
    logic [IDX_BITS-1:0] idx;
    case (count)
      4'd1:    idx = 4'd8;
      4'd2:    idx = 4'd8;
      4'd3:    idx = 4'd7;
      4'd4:    idx = 4'd7;
      4'd5:    idx = 4'd6;
      4'd6:    idx = 4'd6;
      4'd7:    idx = 4'd5;
      4'd8:    idx = 4'd5;
      4'd9:    idx = 4'd4;
      default: idx = 4'd0;
    endcase
    return idx;
  endfunction

endpackage

[rtl/vdm_border.sv]
// first stage: edge replication of the window and valid sample count
`timescale 1ns / 1ps

module vdm_border
  import vdm_pkg::*;
#(
  parameter int SAMPLE_BITS = VDM_SAMPLE_BITS,
  parameter int COORD_BITS  = VDM_COORD_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic [SAMPLE_BITS-1:0] win_in [WIN_TAPS],
  input  logic [COORD_BITS-1:0]  centre_col,
  input  logic [COORD_BITS-1:0]  centre_row,
  input  logic [DIM_BITS-1:0]    frame_width,
  input  logic [DIM_BITS-1:0]    frame_height,
  output logic [SAMPLE_BITS-1:0] win_out [WIN_TAPS],
  output vdm_ctrl_t              ctrl_out
);

  localparam int CMP_BITS = (COORD_BITS + 1 > DIM_BITS) ? COORD_BITS + 1 : DIM_BITS;

  logic [CMP_BITS-1:0]    col_next;
  logic [CMP_BITS-1:0]    row_next;
  logic                   left_edge;
  logic                   right_edge;
  logic                   top_edge;
  logic                   bottom_edge;
  logic [SAMPLE_BITS-1:0] win_next [WIN_TAPS];
  logic [CNT_BITS-1:0]    count_next;

  assign col_next    = CMP_BITS'(centre_col) + CMP_BITS'(1);
  assign row_next    = CMP_BITS'(centre_row) + CMP_BITS'(1);
  assign left_edge   = (centre_col == '0);
  assign top_edge    = (centre_row == '0);
  assign right_edge  = (col_next >= CMP_BITS'(frame_width));
  assign bottom_edge = (row_next >= CMP_BITS'(frame_height));

  always_comb begin
    logic [1:0] r;
    logic [1:0] c;
    count_next = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        r = 2'(i);
        c = 2'(j);
        if ((i == 0 && top_edge) || (i == 2 && bottom_edge)) begin
          r = 2'd1;
        end
        if ((j == 0 && left_edge) || (j == 2 && right_edge)) begin
          c = 2'd1;
        end
        win_next[i*3+j] = win_in[IDX_BITS'(r) * IDX_BITS'(3) + IDX_BITS'(c)];
        count_next = count_next + CNT_BITS'(win_next[i*3+j] != '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    win_out <= win_next;
    ctrl_out.count <= count_next;
    if (rst) begin
      ctrl_out.valid <= 1'b0;
    end else begin
      ctrl_out.valid <= in_valid;
    end
  end

endmodule

[rtl/vdm_sort_stage.sv]
// one register stage of the odd-even transposition sorting network
`timescale 1ns / 1ps

module vdm_sort_stage
  import vdm_pkg::*;
#(
  parameter int SAMPLE_BITS = VDM_SAMPLE_BITS,
  parameter int FIRST_LAYER = 0
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [SAMPLE_BITS-1:0] data_in  [WIN_TAPS],
  input  vdm_ctrl_t              ctrl_in,
  output logic [SAMPLE_BITS-1:0] data_out [WIN_TAPS],
  output vdm_ctrl_t              ctrl_out
);

  logic [SAMPLE_BITS-1:0] data_next [WIN_TAPS];

  always_comb begin
    logic [SAMPLE_BITS-1:0] lo;
    data_next = data_in;
    for (int l = 0; l < SORT_LAYERS_PER_STAGE; l++) begin
      for (int p = 0; p < WIN_TAPS - 1; p++) begin
        if (((p ^ (FIRST_LAYER + l)) & 1) == 0) begin
          lo = data_next[p];
          if (data_next[p] > data_next[p+1]) begin
            data_next[p]   = data_next[p+1];
            data_next[p+1] = lo;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    data_out <= data_next;
    ctrl_out.count <= ctrl_in.count;
    if (rst) begin
      ctrl_out.valid <= 1'b0;
    end else begin
      ctrl_out.valid <= ctrl_in.valid;
    end
  end

endmodule

[rtl/vdm_select.sv]
// output stage: picks the upper median from the sorted taps
`timescale 1ns / 1ps

module vdm_select
  import vdm_pkg::*;
#(
  parameter int SAMPLE_BITS = VDM_SAMPLE_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [SAMPLE_BITS-1:0] sorted [WIN_TAPS],
  input  vdm_ctrl_t              ctrl_in,
  output logic [SAMPLE_BITS-1:0] median_depth,
  output logic [CNT_BITS-1:0]    valid_count,
  output logic                   done
);

  logic [IDX_BITS-1:0]    pick;
  logic [SAMPLE_BITS-1:0] median_next;

  assign pick        = median_index(ctrl_in.count);
  assign median_next = (ctrl_in.count == '0) ? '0 : sorted[pick];

  always_ff @(posedge clk) begin
    median_depth <= median_next;
    valid_count  <= ctrl_in.count;
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctrl_in.valid;
    end
  end

endmodule

[rtl/valid_depth_median_3x3_core.sv]
// One request per clock: a request is taken at each edge with start high (busy stays
// low), and its result shows on median_depth and valid_count with done high for one
// cycle, once it has passed all five register stages: edge replication with the
// valid count, three stages of a nine-tap odd-even transposition sorting network
// (three layers each), and the median pick. The receiver cannot stall the pipeline.
// frame_width and frame_height are written through cfg_wr, cfg_index and cfg_data.
`timescale 1ns / 1ps

module valid_depth_median_3x3_core
  import vdm_pkg::*;
#(
  parameter int SAMPLE_BITS = VDM_SAMPLE_BITS,
  parameter int COORD_BITS  = VDM_COORD_BITS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic [SAMPLE_BITS-1:0]  s_nw,
  input  logic [SAMPLE_BITS-1:0]  s_n,
  input  logic [SAMPLE_BITS-1:0]  s_ne,
  input  logic [SAMPLE_BITS-1:0]  s_w,
  input  logic [SAMPLE_BITS-1:0]  s_c,
  input  logic [SAMPLE_BITS-1:0]  s_e,
  input  logic [SAMPLE_BITS-1:0]  s_sw,
  input  logic [SAMPLE_BITS-1:0]  s_s,
  input  logic [SAMPLE_BITS-1:0]  s_se,
  input  logic [COORD_BITS-1:0]   centre_col,
  input  logic [COORD_BITS-1:0]   centre_row,
  output logic                    done,
  output logic [SAMPLE_BITS-1:0]  median_depth,
  output logic [CNT_BITS-1:0]     valid_count,
  input  logic                    cfg_wr,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [DIM_BITS-1:0]     cfg_data
);

  logic [DIM_BITS-1:0]    frame_width;
  logic [DIM_BITS-1:0]    frame_height;
  logic [SAMPLE_BITS-1:0] win_in [WIN_TAPS];
  logic [SAMPLE_BITS-1:0] stage_data [SORT_STAGES+1][WIN_TAPS];
  vdm_ctrl_t              stage_ctrl [SORT_STAGES+1];
  logic                   accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign win_in[0] = s_nw;
  assign win_in[1] = s_n;
  assign win_in[2] = s_ne;
  assign win_in[3] = s_w;
  assign win_in[4] = s_c;
  assign win_in[5] = s_e;
  assign win_in[6] = s_sw;
  assign win_in[7] = s_s;
  assign win_in[8] = s_se;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RST;
      frame_height <= FRAME_HEIGHT_RST;
    end else if (cfg_wr) begin
      case (cfg_reg_t'(cfg_index))
        REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  vdm_border #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .COORD_BITS (COORD_BITS)
  ) u_border (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (accept),
    .win_in      (win_in),
    .centre_col  (centre_col),
    .centre_row  (centre_row),
    .frame_width (frame_width),
    .frame_height(frame_height),
    .win_out     (stage_data[0]),
    .ctrl_out    (stage_ctrl[0])
  );

  for (genvar g = 0; g < SORT_STAGES; g++) begin : g_sort
    vdm_sort_stage #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .FIRST_LAYER(g * SORT_LAYERS_PER_STAGE)
    ) u_sort (
      .clk     (clk),
      .rst     (rst),
      .data_in (stage_data[g]),
      .ctrl_in (stage_ctrl[g]),
      .data_out(stage_data[g+1]),
      .ctrl_out(stage_ctrl[g+1])
    );
  end

  vdm_select #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_select (
    .clk         (clk),
    .rst         (rst),
    .sorted      (stage_data[SORT_STAGES]),
    .ctrl_in     (stage_ctrl[SORT_STAGES]),
    .median_depth(median_depth),
    .valid_count (valid_count),
    .done        (done)
  );

  // every result traces back to an earlier accepted request
  assert property (@(posedge clk) disable iff (rst) done |-> $past(accept, 5))
    else $error("result without a matching request");

  assert property (@(posedge clk) disable iff (rst) done |-> valid_count <= CNT_BITS'(WIN_TAPS))
    else $error("valid count above window size");

  assert property (@(posedge clk) disable iff (rst)
    done && valid_count == '0 |-> median_depth == '0)
    else $error("nonzero median with no valid sample");

  assert property (@(posedge clk) disable iff (rst)
    done && valid_count != '0 |-> median_depth != '0)
    else $error("invalid sample picked as median");

endmodule

[test/valid_depth_median_3x3_core_test.sv]
// self-checking testbench for the 3x3 valid depth median core: directed table then random windows
`timescale 1ns / 1ps

module valid_depth_median_3x3_core_test;
  import vdm_pkg::*;

  localparam int SB = VDM_SAMPLE_BITS;
  localparam int CB = VDM_COORD_BITS;
  localparam int N_DIRECTED = 19;
  localparam int N_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 200;
  localparam int PIPE_CYCLES = 8;

  typedef struct packed {
    logic [SB-1:0] nw, n, ne, w, c, e, sw, s, se;
    logic [CB-1:0] col, row;
  } win_req_t;

  typedef struct packed {
    logic [SB-1:0]       median;
    logic [CNT_BITS-1:0] count;
  } depth_res_t;

  typedef struct packed {
    win_req_t   req;
    logic       known;
    depth_res_t res;
  } dir_row_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    start = 1'b0;
  logic                    busy;
  logic [SB-1:0]           s_nw = '0, s_n = '0, s_ne = '0, s_w = '0, s_c = '0;
  logic [SB-1:0]           s_e = '0, s_sw = '0, s_s = '0, s_se = '0;
  logic [CB-1:0]           centre_col = '0, centre_row = '0;
  logic                    done;
  logic [SB-1:0]           median_depth;
  logic [CNT_BITS-1:0]     valid_count;
  logic                    cfg_wr = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = REG_FRAME_WIDTH;
  logic [DIM_BITS-1:0]     cfg_data = '0;

  logic [DIM_BITS-1:0] frame_w = FRAME_WIDTH_RST;
  logic [DIM_BITS-1:0] frame_h = FRAME_HEIGHT_RST;
  win_req_t            cur_req = '0;
  logic                cur_known = 1'b0;
  depth_res_t          cur_typed = '0;
  depth_res_t          expected_medians[$];
  int unsigned         accepted_cnt = 0;
  int unsigned         mismatch_count = 0;
  bit                  gappy = 1'b0;

  valid_depth_median_3x3_core uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .s_nw(s_nw), .s_n(s_n), .s_ne(s_ne), .s_w(s_w), .s_c(s_c), .s_e(s_e),
    .s_sw(s_sw), .s_s(s_s), .s_se(s_se),
    .centre_col(centre_col), .centre_row(centre_row),
    .done(done), .median_depth(median_depth), .valid_count(valid_count),
    .cfg_wr(cfg_wr), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  function automatic depth_res_t predict_median(input win_req_t r);
    logic [SB-1:0] grid[9];
    logic [SB-1:0] vals[9];
    int            rs[3];
    int            cs[3];
    int            cnt;
    int            k;
    logic [SB-1:0] d;
    depth_res_t    res;
    grid[0] = r.nw; grid[1] = r.n; grid[2] = r.ne;
    grid[3] = r.w;  grid[4] = r.c; grid[5] = r.e;
    grid[6] = r.sw; grid[7] = r.s; grid[8] = r.se;
    for (int i = 0; i < 9; i++) vals[i] = '0;
    // borders replicate the centre row or column
    rs[0] = (r.row == 0) ? 1 : 0;
    rs[1] = 1;
    rs[2] = ((32'(r.row) + 1) >= 32'(frame_h)) ? 1 : 2;
    cs[0] = (r.col == 0) ? 1 : 0;
    cs[1] = 1;
    cs[2] = ((32'(r.col) + 1) >= 32'(frame_w)) ? 1 : 2;
    cnt = 0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        d = grid[rs[i] * 3 + cs[j]];
        if (d != 0) begin
          k = cnt;
          while (k > 0 && vals[k - 1] > d) begin
            vals[k] = vals[k - 1];
            k--;
          end
          vals[k] = d;
          cnt++;
        end
      end
    end
    res.median = (cnt == 0) ? '0 : vals[cnt / 2];
    res.count = CNT_BITS'(cnt);
    return res;
  endfunction

  function automatic win_req_t mk_win(input int a0, a1, a2, a3, a4, a5, a6, a7, a8,
                                      input int col, row);
    win_req_t r;
    r.nw = SB'(a0); r.n = SB'(a1); r.ne = SB'(a2);
    r.w  = SB'(a3); r.c = SB'(a4); r.e  = SB'(a5);
    r.sw = SB'(a6); r.s = SB'(a7); r.se = SB'(a8);
    r.col = CB'(col);
    r.row = CB'(row);
    return r;
  endfunction

  // directed stimulus at the reset frame size of 1280 x 720
  function automatic dir_row_t directed_row(input int i);
    dir_row_t d;
    d.known = 1'b0;
    d.res = '0;
    case (i)
      0:  begin
        d.req = mk_win(0, 0, 0, 0, 0, 0, 0, 0, 0, 5, 5);
        d.known = 1'b1; d.res = {16'd0, 4'd0};
      end
      1:  begin
        d.req = mk_win(65535, 65535, 65535, 65535, 65535, 65535, 65535, 65535, 65535, 5, 5);
        d.known = 1'b1; d.res = {16'd65535, 4'd9};
      end
      2:  begin
        d.req = mk_win(1, 1, 1, 1, 1, 1, 1, 1, 1, 0, 0);
        d.known = 1'b1; d.res = {16'd1, 4'd9};
      end
      3:  begin
        d.req = mk_win(0, 0, 0, 0, 7, 0, 0, 0, 0, 640, 360);
        d.known = 1'b1; d.res = {16'd7, 4'd1};
      end
      4:  d.req = mk_win(1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 10);
      5:  d.req = mk_win(1, 2, 3, 4, 5, 6, 7, 8, 9, 0, 10);
      6:  d.req = mk_win(1, 2, 3, 4, 5, 6, 7, 8, 9, 1279, 10);
      7:  d.req = mk_win(1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 0);
      8:  d.req = mk_win(1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 719);
      9:  d.req = mk_win(9, 8, 7, 6, 5, 4, 3, 2, 1, 0, 0);
      10: d.req = mk_win(9, 8, 7, 6, 5, 4, 3, 2, 1, 1279, 719);
      11: d.req = mk_win(1, 2, 3, 4, 5, 6, 7, 8, 9, 4095, 4095);
      12: d.req = mk_win(1, 2, 3, 4, 5, 6, 7, 8, 9, 1280, 720);
      13: d.req = mk_win(1, 2, 3, 4, 5, 6, 7, 8, 9, 1278, 718);
      14: d.req = mk_win(0, 300, 0, 100, 0, 200, 0, 400, 0, 20, 20);
      15: d.req = mk_win(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555,
                         16'hAAAA, 16'h5555, 16'hAAAA, 12'hAAA, 12'h555);
      16: d.req = mk_win(5, 5, 3, 3, 0, 9, 9, 9, 0, 0, 1);
      17: d.req = mk_win(65535, 1, 65535, 1, 0, 1, 65535, 0, 65535, 100, 100);
      default: d.req = mk_win(4, 4, 0, 4, 0, 0, 0, 0, 0, 0, 0);
    endcase
    return d;
  endfunction

  function automatic logic [SB-1:0] pick_sample(input int zero_pct);
    if ($urandom_range(0, 99) < zero_pct) return '0;
    case ($urandom_range(0, 5))
      0:       return SB'(1);
      1:       return '1;
      2:       return SB'($urandom_range(1, 8));
      default: return SB'($urandom);
    endcase
  endfunction

  function automatic logic [CB-1:0] pick_coord(input int unsigned dim);
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return CB'(dim - 1);
      2:       return CB'(dim - 2);
      3:       return CB'(dim);
      4:       return '1;
      5, 6:    return (dim > 0) ? CB'($urandom_range(0, dim - 1)) : '0;
      default: return CB'($urandom);
    endcase
  endfunction

  always @(posedge clk) begin
    depth_res_t want;
    if (!rst) begin
      if (start && !busy) begin
        want = cur_known ? cur_typed : predict_median(cur_req);
        expected_medians.insert(expected_medians.size(), want);
        accepted_cnt++;
      end
      if (done !== 1'b0) begin
        if (expected_medians.size() == 0) begin
          $display("%0t: result with none expected: median %0d count %0d",
                   $time, median_depth, valid_count);
          mismatch_count++;
        end else begin
          want = expected_medians.pop_front();
          if (done !== 1'b1 || median_depth !== want.median) begin
            $display("%0t: median_depth expected %0d actual %0d",
                     $time, want.median, median_depth);
            mismatch_count++;
          end
          if (valid_count !== want.count) begin
            $display("%0t: valid_count expected %0d actual %0d",
                     $time, want.count, valid_count);
            mismatch_count++;
          end
        end
      end
    end
  end

  task automatic idle_gap();
    int unsigned roll;
    int unsigned len;
    roll = $urandom_range(0, 99);
    if (!gappy || roll < 50) len = 0;
    else if (roll < 85) len = $urandom_range(1, 3);
    else if (roll < 97) len = $urandom_range(4, 10);
    else len = $urandom_range(20, 60);
    if (len > 0) begin
      start = 1'b0;
      repeat (len) @(negedge clk);
    end
  endtask

  // called at a falling edge; returns at a falling edge after acceptance and any idle gap
  task automatic issue(input win_req_t r, input logic known, input depth_res_t typed);
    int unsigned seen;
    cur_req = r;
    cur_known = known;
    cur_typed = typed;
    s_nw = r.nw; s_n = r.n; s_ne = r.ne;
    s_w  = r.w;  s_c = r.c; s_e  = r.e;
    s_sw = r.sw; s_s = r.s; s_se = r.se;
    centre_col = r.col;
    centre_row = r.row;
    start = 1'b1;
    seen = accepted_cnt;
    do @(negedge clk); while (accepted_cnt == seen);
    idle_gap();
  endtask

  task automatic drain();
    start = 1'b0;
    while (expected_medians.size() != 0) @(negedge clk);
    repeat (PIPE_CYCLES) @(negedge clk);
  endtask

  task automatic write_dims(input logic [DIM_BITS-1:0] w, input logic [DIM_BITS-1:0] h);
    cfg_wr = 1'b1;
    cfg_index = REG_FRAME_WIDTH;
    cfg_data = w;
    @(negedge clk);
    cfg_index = REG_FRAME_HEIGHT;
    cfg_data = h;
    @(negedge clk);
    cfg_wr = 1'b0;
    frame_w = w;
    frame_h = h;
  endtask

  initial begin
    dir_row_t      row;
    win_req_t      r;
    int            zero_pct;
    int            waited;
    logic [DIM_BITS-1:0] w, h;
    repeat (4) @(negedge clk);
    rst = 1'b0;
    gappy = 1'b1;
    for (int i = 0; i < N_DIRECTED; i++) begin
      row = directed_row(i);
      issue(row.req, row.known, row.res);
    end
    drain();
    for (int p = 0; p < N_PHASES; p++) begin
      case (p)
        0:       begin w = FRAME_WIDTH_RST; h = FRAME_HEIGHT_RST; end
        1:       begin w = 13'd1;    h = 13'd1;    end
        2:       begin w = 13'd4096; h = 13'd4096; end
        3:       begin w = 13'd0;    h = 13'd0;    end
        4:       begin w = 13'd8191; h = 13'd8191; end
        5:       begin w = 13'd2;    h = 13'd4096; end
        6:       begin w = DIM_BITS'($urandom_range(1, 4096));
                       h = DIM_BITS'($urandom_range(1, 4096)); end
        default: begin w = 13'd640;  h = 13'd480;  end
      endcase
      drain();
      write_dims(w, h);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (i % 50 == 0) gappy = $urandom_range(0, 1);
        // sender holds off until the pipeline is empty
        if (p == 0 && i == ITEMS_PER_PHASE / 2) drain();
        zero_pct = $urandom_range(0, 100);
        r.nw = pick_sample(zero_pct); r.n = pick_sample(zero_pct);
        r.ne = pick_sample(zero_pct); r.w = pick_sample(zero_pct);
        r.c  = pick_sample(zero_pct); r.e = pick_sample(zero_pct);
        r.sw = pick_sample(zero_pct); r.s = pick_sample(zero_pct);
        r.se = pick_sample(zero_pct);
        r.col = pick_coord(frame_w);
        r.row = pick_coord(frame_h);
        issue(r, 1'b0, '0);
      end
    end
    start = 1'b0;
    waited = 0;
    while (expected_medians.size() != 0 && waited < 200) begin
      @(negedge clk);
      waited++;
    end
    repeat (PIPE_CYCLES) @(negedge clk);
    if (expected_medians.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, expected_medians.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

endmodule
